### rtl/mtlp_pkg.sv
// shared types and constants for the motor telemetry line parser
// depends on nothing; used by mtlp_front, mtlp_queue, mtlp_back and the top level
`default_nettype none

package mtlp_pkg;

   // width of the held speed and angle values
   localparam int VALUE_BITS = 32;
   // token magnitude register, one bit above the value so that saturation is visible
   localparam int ACC_W = VALUE_BITS + 1;
   // largest magnitude a negative token may carry
   localparam logic [ACC_W-1:0] MAG_LIMIT = ACC_W'(1) << (VALUE_BITS - 1);

   // line framing
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [2:0] MIN_LINE_LEN = 3'd5;
   localparam logic [1:0] SPACES_NEEDED = 2'd3;

   // event queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // one finished, counted line as judged by the front
   typedef struct packed {
      logic                  channel;
      logic                  speed_ok;
      logic [VALUE_BITS-1:0] speed;
      logic                  angle_ok;
      logic [VALUE_BITS-1:0] angle;
   } line_event_type;

endpackage

`default_nettype wire

### rtl/mtlp_front.sv
// front end: takes bytes, tracks the current line and parses speed and angle tokens
// depends on mtlp_pkg; pushes one line event per counted line into mtlp_queue
`default_nettype none

module mtlp_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    byte_accept,
   input  wire logic [7:0]              rx_byte,
   output logic                         push,
   output mtlp_pkg::line_event_type     push_data
);

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_SIGN,
      PH_DIGITS,
      PH_STOP
   } phase_type;

   typedef struct packed {
      phase_type                      phase;
      logic                           neg;
      logic [mtlp_pkg::ACC_W-1:0]     acc;
      logic                           ovf;
   } token_type;

   typedef struct packed {
      logic                              ok;
      logic [mtlp_pkg::VALUE_BITS-1:0]   value;
   } value_type;

   localparam token_type TOKEN_CLEAR = '{phase: PH_LEAD, neg: 1'b0, acc: '0, ovf: 1'b0};

   // one character of atoi-style parsing
   function automatic token_type token_feed(token_type t, logic [7:0] c);
      token_type                     r;
      logic                          digit;
      logic                          blank;
      logic [mtlp_pkg::ACC_W+3:0]    nxt;
      r     = t;
      digit = (c >= 8'h30) && (c <= 8'h39);
      blank = (c == mtlp_pkg::CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
      // times ten plus digit, as two shifts and two adds
      nxt   = ({4'b0000, t.acc} << 3) + ({4'b0000, t.acc} << 1)
              + {{mtlp_pkg::ACC_W{1'b0}}, c[3:0]};
      if (t.phase != PH_STOP) begin
         if (digit) begin
            r.phase = PH_DIGITS;
            if (nxt > {4'b0000, mtlp_pkg::MAG_LIMIT}) begin
               r.ovf = 1'b1;
               r.acc = mtlp_pkg::MAG_LIMIT + mtlp_pkg::ACC_W'(1);
            end else begin
               r.acc = nxt[mtlp_pkg::ACC_W-1:0];
            end
         end else begin
            case (t.phase)
               PH_LEAD: begin
                  if (!blank) begin
                     if ((c == 8'h2B) || (c == 8'h2D)) begin
                        r.neg   = (c == 8'h2D);
                        r.phase = PH_SIGN;
                     end else begin
                        r.ovf   = 1'b1;
                        r.phase = PH_STOP;
                     end
                  end
               end
               PH_SIGN: begin
                  r.ovf   = 1'b1;
                  r.phase = PH_STOP;
               end
               default: begin
                  r.phase = PH_STOP;
               end
            endcase
         end
      end
      return r;
   endfunction

   // final value of a token and whether it is in range
   function automatic value_type token_value(token_type t);
      value_type                    r;
      logic [mtlp_pkg::ACC_W-1:0]   negated;
      negated = '0 - t.acc;
      r.ok    = !t.ovf && ((t.phase == PH_DIGITS) || (t.phase == PH_STOP));
      if (t.neg) begin
         r.ok    = r.ok && (t.acc <= mtlp_pkg::MAG_LIMIT);
         r.value = negated[mtlp_pkg::VALUE_BITS-1:0];
      end else begin
         r.ok    = r.ok && (t.acc < mtlp_pkg::MAG_LIMIT);
         r.value = t.acc[mtlp_pkg::VALUE_BITS-1:0];
      end
      return r;
   endfunction

   logic [2:0]                       line_len_ff,  line_len_in;
   logic [1:0]                       prefix_ff,    prefix_in;
   logic [1:0]                       spaces_ff,    spaces_in;
   logic                             skip_ff,      skip_in;
   token_type                        token_ff,     token_in;
   logic [mtlp_pkg::VALUE_BITS-1:0]  speed_ff,     speed_in;
   logic                             speed_ok_ff,  speed_ok_in;

   logic       is_newline;
   logic       line_counts;
   value_type  token_now;

   assign is_newline  = (rx_byte == mtlp_pkg::CHAR_NEWLINE);
   assign token_now   = token_value(token_ff);
   assign line_counts = (line_len_ff == mtlp_pkg::MIN_LINE_LEN)
                        && (spaces_ff == mtlp_pkg::SPACES_NEEDED) && (prefix_ff != 2'b00);

   // event for a counted line
   assign push               = byte_accept && is_newline && line_counts;
   assign push_data.channel  = !prefix_ff[0];
   assign push_data.speed_ok = speed_ok_ff;
   assign push_data.speed    = speed_ff;
   assign push_data.angle_ok = token_now.ok;
   assign push_data.angle    = token_now.value;

   // next line state for the byte at the input
   always_comb begin
      line_len_in = line_len_ff;
      prefix_in   = prefix_ff;
      spaces_in   = spaces_ff;
      skip_in     = skip_ff;
      token_in    = token_ff;
      speed_in    = speed_ff;
      speed_ok_in = speed_ok_ff;
      if (is_newline) begin
         line_len_in = '0;
         prefix_in   = 2'b11;
         spaces_in   = '0;
         skip_in     = 1'b0;
         token_in    = TOKEN_CLEAR;
         speed_in    = '0;
         speed_ok_in = 1'b0;
      end else begin
         // prefix check on the first four characters
         if (line_len_ff < 3'd4) begin
            unique case (line_len_ff[1:0])
               2'd0: if (rx_byte != 8'h50) prefix_in = 2'b00;
               2'd1: begin
                  if (rx_byte != 8'h30) prefix_in[0] = 1'b0;
                  if (rx_byte != 8'h31) prefix_in[1] = 1'b0;
               end
               2'd2: if (rx_byte != 8'h43) prefix_in = 2'b00;
               2'd3: if (rx_byte != 8'h30) prefix_in = 2'b00;
            endcase
         end
         if (line_len_ff < mtlp_pkg::MIN_LINE_LEN) begin
            line_len_in = line_len_ff + 3'd1;
         end
         // space search and token feed
         if (spaces_ff == 2'd0) begin
            if (rx_byte == mtlp_pkg::CHAR_SPACE) begin
               spaces_in = 2'd1;
               skip_in   = 1'b1;
               token_in  = TOKEN_CLEAR;
            end
         end else if (spaces_ff < mtlp_pkg::SPACES_NEEDED) begin
            if (skip_ff) begin
               skip_in  = 1'b0;
               token_in = token_feed(token_ff, rx_byte);
            end else if (rx_byte == mtlp_pkg::CHAR_SPACE) begin
               if (spaces_ff == 2'd1) begin
                  speed_ok_in = token_now.ok;
                  if (token_now.ok) begin
                     speed_in = token_now.value;
                  end
                  token_in = TOKEN_CLEAR;
               end
               spaces_in = spaces_ff + 2'd1;
               skip_in   = (spaces_ff == 2'd1);
            end else begin
               token_in = token_feed(token_ff, rx_byte);
            end
         end
      end
   end

   // line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_len_ff <= '0;
         prefix_ff   <= 2'b11;
         spaces_ff   <= '0;
         skip_ff     <= 1'b0;
         token_ff    <= TOKEN_CLEAR;
         speed_ff    <= '0;
         speed_ok_ff <= 1'b0;
      end else if (byte_accept) begin
         line_len_ff <= line_len_in;
         prefix_ff   <= prefix_in;
         spaces_ff   <= spaces_in;
         skip_ff     <= skip_in;
         token_ff    <= token_in;
         speed_ff    <= speed_in;
         speed_ok_ff <= speed_ok_in;
      end
   end

endmodule

`default_nettype wire

### rtl/mtlp_queue.sv
// short event queue that decouples the byte front end from the result back end
// depends on mtlp_pkg for the event type and depth
`default_nettype none

module mtlp_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire mtlp_pkg::line_event_type   push_data,
   input  wire logic                       pop,
   output mtlp_pkg::line_event_type        pop_data,
   output logic                            full,
   output logic                            empty
);

   mtlp_pkg::line_event_type          mem_ff [mtlp_pkg::QUEUE_DEPTH];
   logic [mtlp_pkg::QPTR_W-1:0]       wr_ptr_ff;
   logic [mtlp_pkg::QPTR_W-1:0]       rd_ptr_ff;
   logic [mtlp_pkg::QCOUNT_W-1:0]     count_ff;

   localparam logic [mtlp_pkg::QPTR_W-1:0] PTR_LAST = mtlp_pkg::QPTR_W'(mtlp_pkg::QUEUE_DEPTH - 1);
   localparam logic [mtlp_pkg::QCOUNT_W-1:0] COUNT_FULL =
      mtlp_pkg::QCOUNT_W'(mtlp_pkg::QUEUE_DEPTH);

   assign full     = (count_ff == COUNT_FULL);
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // storage write
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // queue usage checks
   a_no_push_full: assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("event pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) empty |-> !pop)
      else $error("event popped from an empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("queue count beyond depth");
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a lone push");

endmodule

`default_nettype wire

### rtl/mtlp_back.sv
// back end: applies line events to the held values and drives the result register
// depends on mtlp_pkg; takes events from mtlp_queue
`default_nettype none

module mtlp_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               empty,
   input  wire mtlp_pkg::line_event_type           pop_data,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_channel,
   output logic signed [mtlp_pkg::VALUE_BITS-1:0]  rsp_speed_value,
   output logic signed [mtlp_pkg::VALUE_BITS-1:0]  rsp_angle_value,
   output logic                                    rsp_speed_updated,
   output logic                                    rsp_angle_updated
);

   logic [mtlp_pkg::VALUE_BITS-1:0]  held_speed_ff [2];
   logic [mtlp_pkg::VALUE_BITS-1:0]  held_angle_ff [2];
   logic [mtlp_pkg::VALUE_BITS-1:0]  speed_in;
   logic [mtlp_pkg::VALUE_BITS-1:0]  angle_in;

   logic                             valid_ff;
   logic                             channel_ff;
   logic [mtlp_pkg::VALUE_BITS-1:0]  speed_ff;
   logic [mtlp_pkg::VALUE_BITS-1:0]  angle_ff;
   logic                             speed_upd_ff;
   logic                             angle_upd_ff;

   // take an event when the result register is free or being emptied
   assign pop = !empty && (!valid_ff || !rsp_stall);

   // held pair of the event's channel after this line
   assign speed_in = pop_data.speed_ok ? pop_data.speed : held_speed_ff[pop_data.channel];
   assign angle_in = pop_data.angle_ok ? pop_data.angle : held_angle_ff[pop_data.channel];

   // held values per channel
   always_ff @(posedge clock) begin
      if (reset) begin
         held_speed_ff[0] <= '0;
         held_speed_ff[1] <= '0;
         held_angle_ff[0] <= '0;
         held_angle_ff[1] <= '0;
      end else if (pop) begin
         held_speed_ff[pop_data.channel] <= speed_in;
         held_angle_ff[pop_data.channel] <= angle_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         channel_ff   <= pop_data.channel;
         speed_ff     <= speed_in;
         angle_ff     <= angle_in;
         speed_upd_ff <= pop_data.speed_ok;
         angle_upd_ff <= pop_data.angle_ok;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_channel       = channel_ff;
   assign rsp_speed_value   = $signed(speed_ff);
   assign rsp_angle_value   = $signed(angle_ff);
   assign rsp_speed_updated = speed_upd_ff;
   assign rsp_angle_updated = angle_upd_ff;

endmodule

`default_nettype wire

### rtl/motor_telemetry_line_parser.sv
// Motor telemetry line parser, top level.
// The req channel carries one received text byte per transfer (req_rx_byte).
// Bytes build up a line; at each newline the line is judged. A line that is
// at least five bytes, starts with P0C0 or P1C0 and holds three spaces gives
// one transfer on the rsp channel: the channel, the held speed and angle of
// that channel after the line, and a flag per value that says whether its
// token parsed and was stored. Other lines give nothing.
// Throughput: one byte per cycle while req_stall is low. The per-byte work
// is a compare and a times-ten accumulate in the front end, done in the
// cycle of the transfer. A line event is written into the event queue and
// is then taken into the result register, which drives rsp_valid.
// When the receiver stalls, the result register holds, the back end stops
// taking events and the two-entry queue fills; req_stall rises only while
// the queue is full. Reset (synchronous, active high) clears the partial
// line, empties the queue, drops rsp_valid and zeroes the held values.
// Depends on mtlp_pkg, mtlp_front, mtlp_queue and mtlp_back.
`default_nettype none

module motor_telemetry_line_parser (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [7:0]                          req_rx_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_channel,
   output logic signed [mtlp_pkg::VALUE_BITS-1:0]   rsp_speed_value,
   output logic signed [mtlp_pkg::VALUE_BITS-1:0]   rsp_angle_value,
   output logic                                     rsp_speed_updated,
   output logic                                     rsp_angle_updated
);

   logic                       byte_accept;
   logic                       push;
   mtlp_pkg::line_event_type   push_data;
   logic                       pop;
   mtlp_pkg::line_event_type   pop_data;
   logic                       full;
   logic                       empty;

   // input transfer
   assign req_stall   = full;
   assign byte_accept = req_valid && !req_stall;

   mtlp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .push        (push),
      .push_data   (push_data)
   );

   mtlp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   mtlp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .empty             (empty),
      .pop_data          (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel       (rsp_channel),
      .rsp_speed_value   (rsp_speed_value),
      .rsp_angle_value   (rsp_angle_value),
      .rsp_speed_updated (rsp_speed_updated),
      .rsp_angle_updated (rsp_angle_updated)
   );

endmodule

`default_nettype wire
